/* rtl/hlru_pkg.sv */
// shared types, constants and codes for the hashed lru entry cache
package hlru_pkg;

   localparam int SLOTS   = 64;
   localparam int IDX_W   = $clog2(SLOTS);
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int LIVE_W  = 7;
   localparam int KEY_W   = 64;
   localparam int MODE_W  = 32;
   localparam int SIZE_W  = 64;
   localparam int STAMP_W = 32;

   localparam logic [IDX_W-1:0]   LAST_IDX     = IDX_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0]   SLOTS_CNT    = CNT_W'(SLOTS);
   localparam logic [KEY_W-1:0]   ALL_ONES_KEY = '1;
   localparam logic [STAMP_W-1:0] TOP_STAMP    = '1;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_EVICT  = 2'd2;
   localparam logic [1:0] OP_RSVD   = 2'd3;

   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_VALID = 2'd1,
      SLOT_TOMB  = 2'd2
   } slot_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_PROBE_RD,
      ST_PROBE_CMP,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [MODE_W-1:0]  mode;
      logic [SIZE_W-1:0]  size;
      logic [STAMP_W-1:0] stamp;
   } slot_word_type;

   typedef struct packed {
      logic load;
      logic rd;
      logic probe_eval;
      logic scan_init;
      logic scan_eval;
      logic step;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic       key_ok;
      logic [1:0] op;
      logic       hit_now;
      logic       empty_now;
      logic       free_now;
      logic       last;
      logic       out_free;
   } dp_status_type;

endpackage

/* rtl/hlru_dp.sv */
// datapath: slot memory, slot state flops, probe and scan pointers, result register
module hlru_dp import hlru_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_operation,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [MODE_W-1:0]  req_new_mode,
   input  logic [SIZE_W-1:0]  req_new_size,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_found,
   output logic [MODE_W-1:0]  rsp_found_mode,
   output logic [SIZE_W-1:0]  rsp_found_size,
   output logic               rsp_replaced_victim,
   output logic [LIVE_W-1:0]  rsp_live_count
);

   slot_word_type      mem [SLOTS];
   slot_word_type      rd_ff;
   slot_state_type     slot_st_ff [SLOTS];
   slot_state_type     st_rd_ff;

   logic [1:0]         op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [MODE_W-1:0]  mode_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   cnt_ff;
   logic [IDX_W-1:0]   tgt_ff;
   logic               hit_ff;
   logic               free_ff;
   logic               victim_ff;
   logic [STAMP_W-1:0] best_ff;
   logic [STAMP_W-1:0] tick_ff;
   logic [STAMP_W-1:0] tick_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   logic               rsp_valid_ff;
   logic               found_ff;
   logic [MODE_W-1:0]  fmode_ff;
   logic [SIZE_W-1:0]  fsize_ff;
   logic               repl_ff;
   logic [CNT_W-1:0]   live_ff;

   slot_state_type     cur_st;
   logic               key_ok;
   logic               we;
   slot_word_type      wr_word;
   logic [STAMP_W-1:0] new_tick;

   always_comb begin
      cur_st   = st_rd_ff;
      key_ok   = (key_ff != '0) && (key_ff != ALL_ONES_KEY) &&
                 (op_ff == OP_LOOKUP || op_ff == OP_INSERT || op_ff == OP_EVICT);
      we       = key_ok && (hit_ff || op_ff == OP_INSERT);
      new_tick = tick_ff + 1'b1;

      status.key_ok    = key_ok;
      status.op        = op_ff;
      status.hit_now   = (cur_st == SLOT_VALID) && (rd_ff.key == key_ff);
      status.empty_now = (cur_st == SLOT_EMPTY);
      status.free_now  = free_ff || (cur_st != SLOT_VALID);
      status.last      = (cnt_ff == LAST_IDX);
      status.out_free  = !rsp_valid_ff || rsp_ready;

      wr_word  = '{key: key_ff, mode: mode_ff, size: size_ff, stamp: new_tick};
      if (hit_ff) begin
         case (op_ff)
            OP_LOOKUP: begin
               wr_word       = rd_ff;
               wr_word.stamp = new_tick;
            end
            OP_INSERT: ;
            default:   wr_word = '0;
         endcase
      end

      tick_in  = tick_ff;
      count_in = count_ff;
      if (we) begin
         if (hit_ff && op_ff == OP_EVICT) begin
            if (count_ff != '0) begin
               count_in = count_ff - 1'b1;
            end
         end else begin
            tick_in = new_tick;
            if (!hit_ff && !victim_ff) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   // slot memory: one read and one write port, registered read
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_ff    <= mem[idx_ff];
         st_rd_ff <= slot_st_ff[idx_ff];
      end
      if (cmd.finish && we) begin
         mem[tgt_ff] <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         key_ff  <= req_key;
         mode_ff <= req_new_mode;
         size_ff <= req_new_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_st_ff[i] <= SLOT_EMPTY;
         end
         tick_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         tgt_ff       <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         victim_ff    <= 1'b0;
         best_ff      <= TOP_STAMP;
      end else begin
         if (cmd.load) begin
            idx_ff    <= req_key[IDX_W-1:0];
            cnt_ff    <= '0;
            hit_ff    <= 1'b0;
            free_ff   <= 1'b0;
            victim_ff <= 1'b0;
         end
         if (cmd.probe_eval) begin
            if (status.hit_now) begin
               hit_ff <= 1'b1;
               tgt_ff <= idx_ff;
            end else if (cur_st != SLOT_VALID && !free_ff) begin
               free_ff <= 1'b1;
               tgt_ff  <= idx_ff;
            end
         end
         if (cmd.scan_eval && rd_ff.stamp < best_ff) begin
            best_ff <= rd_ff.stamp;
            tgt_ff  <= idx_ff;
         end
         if (cmd.step) begin
            idx_ff <= idx_ff + 1'b1;
            cnt_ff <= cnt_ff + 1'b1;
         end
         // lru sweep starts over from slot 0
         if (cmd.scan_init) begin
            idx_ff    <= '0;
            cnt_ff    <= '0;
            tgt_ff    <= '0;
            best_ff   <= TOP_STAMP;
            victim_ff <= 1'b1;
         end
         if (cmd.finish) begin
            tick_ff  <= tick_in;
            count_ff <= count_in;
            if (we) begin
               slot_st_ff[tgt_ff] <= (hit_ff && op_ff == OP_EVICT) ? SLOT_TOMB : SLOT_VALID;
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         found_ff <= key_ok && hit_ff;
         fmode_ff <= (key_ok && hit_ff && op_ff == OP_LOOKUP) ? rd_ff.mode : '0;
         fsize_ff <= (key_ok && hit_ff && op_ff == OP_LOOKUP) ? rd_ff.size : '0;
         repl_ff  <= key_ok && !hit_ff && op_ff == OP_INSERT && victim_ff;
         live_ff  <= count_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = found_ff;
   assign rsp_found_mode      = fmode_ff;
   assign rsp_found_size      = fsize_ff;
   assign rsp_replaced_victim = repl_ff;
   assign rsp_live_count      = LIVE_W'(live_ff);

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SLOTS_CNT)
      else $error("live count above slot total");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished item not shown");

   a_no_write_keeps: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && !we |=> $stable(count_ff) && $stable(tick_ff))
      else $error("state changed without a write");

   a_victim_keeps_count: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && we && victim_ff && !hit_ff |=> $stable(count_ff))
      else $error("replacement changed live count");

endmodule

/* rtl/hlru_ctrl.sv */
// controller: walks the probe sequence, the lru sweep and the result handoff
module hlru_ctrl import hlru_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = status.key_ok ? ST_PROBE_RD : ST_DONE;
         end
         ST_PROBE_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_PROBE_CMP;
         end
         ST_PROBE_CMP: begin
            cmd.probe_eval = 1'b1;
            if (status.hit_now) begin
               state_in = ST_DONE;
            end else if (status.empty_now || status.last) begin
               // full probe path on an insert falls back to the lru sweep
               if (status.op == OP_INSERT && !status.free_now) begin
                  cmd.scan_init = 1'b1;
                  state_in      = ST_SCAN_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               cmd.step = 1'b1;
               state_in = ST_PROBE_RD;
            end
         end
         ST_SCAN_RD: begin
            cmd.rd   = 1'b1;
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            cmd.scan_eval = 1'b1;
            if (status.last) begin
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_START)
      else $error("load outside idle");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> status.out_free)
      else $error("result overwritten");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.rd, cmd.probe_eval, cmd.scan_eval, cmd.finish, cmd.load}))
      else $error("overlapping commands");

endmodule

/* rtl/hashed_lru_entry_cache.sv */
// hashed lru entry cache: linear probing over 64 slots with lru replacement
// an item probes slot by slot from acceptance to result, and an insert into a full table adds
// an lru sweep over all 64 slots; an ignored key goes straight to the result
// throughput: one item at a time, the next accepted in the same cycle the result is first shown
// a finished result sits in an output register while the next item is taken
// reset: synchronous, clears slot states to empty, tick and live count at once
module hashed_lru_entry_cache import hlru_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [MODE_W-1:0]  req_new_mode,
   input  logic [SIZE_W-1:0]  req_new_size,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_found,
   output logic [MODE_W-1:0]  rsp_found_mode,
   output logic [SIZE_W-1:0]  rsp_found_size,
   output logic               rsp_replaced_victim,
   output logic [LIVE_W-1:0]  rsp_live_count
);

   dp_cmd_type    cmd;
   dp_status_type status;

   hlru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hlru_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_operation       (req_operation),
      .req_key             (req_key),
      .req_new_mode        (req_new_mode),
      .req_new_size        (req_new_size),
      .cmd                 (cmd),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_found           (rsp_found),
      .rsp_found_mode      (rsp_found_mode),
      .rsp_found_size      (rsp_found_size),
      .rsp_replaced_victim (rsp_replaced_victim),
      .rsp_live_count      (rsp_live_count)
   );

endmodule

/* tb/tb_hashed_lru_entry_cache.sv */
// testbench for the hashed lru entry cache: directed and random items against a table predictor
`timescale 1ns / 100ps
module tb_hashed_lru_entry_cache;
   import hlru_pkg::*;

   typedef struct packed {
      logic              found;
      logic [MODE_W-1:0] found_mode;
      logic [SIZE_W-1:0] found_size;
      logic              victim;
      logic [LIVE_W-1:0] live;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_operation = OP_LOOKUP;
   logic [KEY_W-1:0] req_key = '0;
   logic [MODE_W-1:0] req_new_mode = '0;
   logic [SIZE_W-1:0] req_new_size = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_found;
   logic [MODE_W-1:0] rsp_found_mode;
   logic [SIZE_W-1:0] rsp_found_size;
   logic rsp_replaced_victim;
   logic [LIVE_W-1:0] rsp_live_count;

   hashed_lru_entry_cache u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   slot_state_type   tbl_state [SLOTS];
   logic [KEY_W-1:0] tbl_key   [SLOTS];
   logic [MODE_W-1:0] tbl_mode [SLOTS];
   logic [SIZE_W-1:0] tbl_size [SLOTS];
   logic [STAMP_W-1:0] tbl_stamp [SLOTS];
   logic [STAMP_W-1:0] tick;
   int unsigned live_total;

   answer_type pending_answers[$];
   int errors = 0;
   bit hold_rsp = 1'b0;
   bit no_idle = 1'b0;
   logic [KEY_W-1:0] used_keys[$];

   task automatic report(input string what, input logic [SIZE_W-1:0] got,
                         input logic [SIZE_W-1:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int find_slot(input logic [KEY_W-1:0] k);
      int idx;
      idx = int'(k % SLOTS);
      for (int n = 0; n < SLOTS; n++) begin
         if (tbl_state[idx] == SLOT_VALID && tbl_key[idx] == k) return idx;
         if (tbl_state[idx] == SLOT_EMPTY) return -1;
         idx = (idx + 1) % SLOTS;
      end
      return -1;
   endfunction

   function automatic answer_type predict_cache(input logic [1:0] op,
                                                input logic [KEY_W-1:0] k,
                                                input logic [MODE_W-1:0] m,
                                                input logic [SIZE_W-1:0] s);
      answer_type a;
      int hit, idx, target;
      bit free_found;
      logic [STAMP_W-1:0] best;
      a = '0;
      if (k != '0 && k != ALL_ONES_KEY && op != OP_RSVD) begin
         hit = find_slot(k);
         if (op == OP_LOOKUP) begin
            if (hit >= 0) begin
               tick = tick + 1;
               tbl_stamp[hit] = tick;
               a.found = 1'b1;
               a.found_mode = tbl_mode[hit];
               a.found_size = tbl_size[hit];
            end
         end else if (op == OP_INSERT) begin
            if (hit >= 0) begin
               tick = tick + 1;
               tbl_stamp[hit] = tick;
               tbl_mode[hit] = m;
               tbl_size[hit] = s;
               a.found = 1'b1;
            end else begin
               idx = int'(k % SLOTS);
               target = 0;
               free_found = 1'b0;
               for (int n = 0; n < SLOTS; n++) begin
                  if (tbl_state[idx] != SLOT_VALID) begin
                     target = idx;
                     free_found = 1'b1;
                     break;
                  end
                  idx = (idx + 1) % SLOTS;
               end
               if (!free_found) begin
                  best = TOP_STAMP;
                  for (int j = 0; j < SLOTS; j++)
                     if (tbl_state[j] == SLOT_VALID && tbl_stamp[j] < best) begin
                        best = tbl_stamp[j];
                        target = j;
                     end
                  a.victim = 1'b1;
               end else begin
                  live_total++;
               end
               tbl_state[target] = SLOT_VALID;
               tbl_key[target] = k;
               tbl_mode[target] = m;
               tbl_size[target] = s;
               tick = tick + 1;
               tbl_stamp[target] = tick;
            end
         end else if (hit >= 0) begin
            tbl_state[hit] = SLOT_TOMB;
            tbl_key[hit] = '0;
            tbl_mode[hit] = '0;
            tbl_size[hit] = '0;
            tbl_stamp[hit] = '0;
            if (live_total > 0) live_total--;
            a.found = 1'b1;
         end
      end
      a.live = LIVE_W'(live_total);
      return a;
   endfunction

   // entered at a falling edge; the previous item stays up only when the next follows at once
   task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] k,
                            input logic [MODE_W-1:0] m, input logic [SIZE_W-1:0] s);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_key <= k;
      req_new_mode <= m;
      req_new_size <= s;
      do @(posedge clock); while (!req_ready);
      pending_answers.push_back(predict_cache(op, k, m, s));
      if (op == OP_INSERT) used_keys.push_back(k);
      @(negedge clock);
   endtask

   // result receiver with random stalls
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 15);
         if (stall != 0 || hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
            while (hold_rsp) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      answer_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            report("unexpected item", '0, '0);
         end else begin
            w = pending_answers.pop_front();
            if (rsp_found !== w.found)
               report("found", SIZE_W'(rsp_found), SIZE_W'(w.found));
            if (rsp_found_mode !== w.found_mode)
               report("found_mode", SIZE_W'(rsp_found_mode), SIZE_W'(w.found_mode));
            if (rsp_found_size !== w.found_size)
               report("found_size", rsp_found_size, w.found_size);
            if (rsp_replaced_victim !== w.victim)
               report("replaced_victim", SIZE_W'(rsp_replaced_victim), SIZE_W'(w.victim));
            if (rsp_live_count !== w.live)
               report("live_count", SIZE_W'(rsp_live_count), SIZE_W'(w.live));
         end
      end
   end

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
   endtask

   function automatic logic [KEY_W-1:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [SIZE_W-1:0] rand_size();
      return {$urandom, $urandom};
   endfunction

   task automatic test_directed();
      send_item(OP_LOOKUP, 64'd5, '1, '1);
      send_item(OP_INSERT, 64'd5, '1, '1);
      send_item(OP_LOOKUP, 64'd5, '0, '0);
      send_item(OP_INSERT, 64'd5, 32'h1234, 64'h55);
      send_item(OP_LOOKUP, 64'd5, '0, '0);
      send_item(OP_INSERT, 64'd69, 32'h7, 64'h9); // collides with 5
      send_item(OP_EVICT, 64'd5, '0, '0);          // tombstone in path
      send_item(OP_LOOKUP, 64'd69, '0, '0);
      send_item(OP_INSERT, 64'd133, '1, '0);       // reuses tombstone
      send_item(OP_INSERT, 64'd0, '1, '1);         // ignored key
      send_item(OP_INSERT, ALL_ONES_KEY, '1, '1);  // ignored key
      send_item(OP_RSVD, 64'd69, '1, '1);          // unknown op
      send_item(OP_EVICT, 64'd999, '0, '0);
      send_item(OP_INSERT, 64'h8000_0000_0000_003f, '1, '1); // fills slot 63 for a wrap probe
      send_item(OP_INSERT, 64'h7fff_ffff_ffff_ffbf, 32'h1, 64'h2);
      send_item(OP_LOOKUP, 64'h7fff_ffff_ffff_ffbf, '0, '0);
      drain();
   endtask

   task automatic test_full_table();
      // fill past 64 entries to force lru sweeps
      for (int i = 0; i < 90; i++)
         send_item(OP_INSERT, rand_key(), $urandom, rand_size());
      for (int i = 0; i < 20; i++)
         send_item(OP_LOOKUP, used_keys[$urandom_range(0, used_keys.size() - 1)], '0, '0);
      for (int i = 0; i < 10; i++)
         send_item(OP_INSERT, rand_key(), $urandom, rand_size());
      drain();
   endtask

   task automatic test_backpressure();
      hold_rsp = 1'b1;
      fork
         begin
            for (int i = 0; i < 8; i++)
               send_item(OP_LOOKUP, used_keys[$urandom_range(0, used_keys.size() - 1)], '0, '0);
         end
         begin
            repeat (1500) @(negedge clock);
            hold_rsp = 1'b0;
         end
      join
      drain();
   endtask

   task automatic test_random();
      logic [1:0] op;
      logic [KEY_W-1:0] k;
      int sel;
      for (int i = 0; i < 500; i++) begin
         if (i == 200) no_idle = 1'b1;
         if (i == 260) no_idle = 1'b0;
         sel = $urandom_range(0, 99);
         op = (sel < 40) ? OP_INSERT : (sel < 70) ? OP_LOOKUP : (sel < 95) ? OP_EVICT : OP_RSVD;
         sel = $urandom_range(0, 99);
         if (sel < 60 && used_keys.size() != 0)
            k = used_keys[$urandom_range(0, used_keys.size() - 1)];
         else if (sel < 64)
            k = (sel[0]) ? '0 : ALL_ONES_KEY;
         else if (sel < 80)
            k = KEY_W'($urandom_range(1, 200));
         else
            k = rand_key();
         send_item(op, k, $urandom, rand_size());
         if (i == 350) drain();
      end
      drain();
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         tbl_state[i] = SLOT_EMPTY;
         tbl_key[i] = '0;
         tbl_mode[i] = '0;
         tbl_size[i] = '0;
         tbl_stamp[i] = '0;
      end
      tick = '0;
      live_total = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_backpressure();
      test_random();
      repeat (300) @(negedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
